/* sv/mac_learning_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the MAC learning table
// Clocked, reset-qualified property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_TABLE_ASSERT_SVH
`define MAC_LEARNING_TABLE_ASSERT_SVH

// Plain clocked property, checked outside reset.
`define MLT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mac learning table check failed");

// Antecedent followed by a consequent in the next cycle.
`define MLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mac learning table sequence check failed");

`endif

/* sv/mlt_pkg.sv */
// ----------------------------------------------------------------------------
// MAC learning table package
// Operation and status codes, slot layout, reset values and hash helpers.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int BUCKETS_DEF = 128;
    localparam int WAYS_DEF    = 4;

    localparam logic [15:0] EXPIRE_RST   = 16'd100;
    localparam logic [7:0]  INTERVAL_RST = 8'd2;

    localparam logic [2:0] OP_LOOKUP   = 3'd0;
    localparam logic [2:0] OP_LEARN    = 3'd1;
    localparam logic [2:0] OP_TOUCH    = 3'd2;
    localparam logic [2:0] OP_DELETE   = 3'd3;
    localparam logic [2:0] OP_DEL_PORT = 3'd4;
    localparam logic [2:0] OP_REASSIGN = 3'd5;
    localparam logic [2:0] OP_TICK     = 3'd6;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic       CFG_EXPIRE   = 1'b0;
    localparam logic       CFG_INTERVAL = 1'b1;

    localparam logic [9:0] REMOVED_MAX = 10'd1023;

    typedef struct packed {
        logic        valid;
        logic [47:0] addr;
        logic [7:0]  port;
        logic [31:0] stamp;
    } t_slot;

    // Residues of 256^i mod 11 are 1, 3, 9, 5: fold the little-endian word.
    function automatic logic [12:0] f_byte_sum(input logic [47:0] mac);
        logic [12:0] b0, b1, b2, b3;
        b0 = {5'd0, mac[47:40]};
        b1 = {5'd0, mac[39:32]};
        b2 = {5'd0, mac[31:24]};
        b3 = {5'd0, mac[23:16]};
        return b0 + 13'd3 * b1 + 13'd9 * b2 + 13'd5 * b3;
    endfunction

    // Reciprocal estimate is at most one low, so one correction suffices.
    function automatic logic [3:0] f_mod11(input logic [12:0] s);
        logic [25:0] prod;
        logic [12:0] q;
        logic [13:0] r;
        prod = {13'd0, s} * 26'd5957;
        q    = prod[25:16] == 10'd0 ? 13'd0 : {3'd0, prod[25:16]};
        r    = {1'b0, s} - 14'(q * 13'd11);
        if (r >= 14'd11) begin
            r = r - 14'd11;
        end
        return r[3:0];
    endfunction

endpackage

/* sv/mac_learning_table.sv */
// ----------------------------------------------------------------------------
// MAC learning table
// Hashed, set-associative station table with learning, deletion and aging.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with operation, mac, port, new_port.
// Output channel: o_out_valid / i_out_stall, one result item per input item.
// Configuration: i_cfg_we writes expire_seconds (index 0) or sweep_interval
// (index 1); the user must write only while the block is idle; the block does not enforce it.
// Lookup, learn, touch and delete hash the address (byte sum on acceptance,
// then states H1 and H2), read one bucket row from the table memory in RD,
// then modify and write it back in EXEC; the push state loads the result
// into the output register, and only then is the next item taken.
// Delete by port, reassign and a tick that triggers a sweep walk every
// bucket row through the single read and write port.
// A tick without a sweep, or an unused code, goes from H1 to the push state.
// After reset the memory is cleared one row a cycle, over every bucket row, with
// o_in_stall held high; configuration writes are taken throughout.
// A stalled result holds in the output register; a finished item waits in
// a push state until that register frees, then the next item is taken.
// ----------------------------------------------------------------------------
`include "mac_learning_table_assert.svh"

module mac_learning_table #(
    parameter int BUCKETS = mlt_pkg::BUCKETS_DEF,
    parameter int WAYS    = mlt_pkg::WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [47:0] i_mac,
    input  logic [7:0]  i_port,
    input  logic [7:0]  i_new_port,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic [7:0]  o_found_port,
    output logic [1:0]  o_status,
    output logic [9:0]  o_removed_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mlt_pkg::*;

    localparam int BW    = $clog2(BUCKETS);
    localparam int RECIP = 65536 / BUCKETS;
    localparam int CW    = $clog2(WAYS + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_H1, S_H2, S_RD, S_EXEC, S_SWEEP, S_PUSH
    } t_state;

    typedef t_slot [WAYS-1:0] t_row;

    t_state      r_state;
    t_row        r_mem [BUCKETS];
    t_row        r_rd_row;

    logic [2:0]  r_op;
    logic [47:0] r_mac;
    logic [7:0]  r_port;
    logic [7:0]  r_new_port;
    logic [12:0] r_sum;
    logic [7:0]  r_x;
    logic [BW-1:0] r_bucket;
    logic [BW:0] r_row;
    logic [BW-1:0] r_wrow;
    logic        r_pend;

    logic [31:0] r_time;
    logic [7:0]  r_div;
    logic [15:0] r_expire;
    logic [7:0]  r_interval;

    logic        r_hit;
    logic [7:0]  r_fport;
    logic [1:0]  r_status;
    logic [9:0]  r_removed;

    logic        r_out_valid;
    logic        r_o_hit;
    logic [7:0]  r_o_fport;
    logic [1:0]  r_o_status;
    logic [9:0]  r_o_removed;

    // Bucket reduction of the 8-bit hash value
    logic [24:0] bprod;
    logic [7:0]  bq;
    logic [10:0] br;

    always_comb begin
        bprod = {17'd0, r_x} * 25'(RECIP);
        bq    = bprod[23:16];
        br    = {3'd0, r_x} - 11'(32'(bq) * BUCKETS);
        if (br >= 11'(BUCKETS)) begin
            br = br - 11'(BUCKETS);
        end
    end

    // Bucket row processing for the single-address operations
    logic [WAYS-1:0] match, free, sel_m, sel_f;
    logic            any_m, any_f;
    logic [7:0]      m_port;
    t_row            ex_row;

    always_comb begin
        any_m  = 1'b0;
        any_f  = 1'b0;
        m_port = 8'd0;
        ex_row = r_rd_row;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = r_rd_row[w].valid && r_rd_row[w].addr == r_mac;
            free[w]  = !r_rd_row[w].valid;
            sel_m[w] = match[w] && !any_m;
            sel_f[w] = free[w] && !any_f;
            any_m    = any_m | match[w];
            any_f    = any_f | free[w];
        end
        for (int w = 0; w < WAYS; w++) begin
            if (sel_m[w]) begin
                m_port = r_rd_row[w].port;
                if (r_op == OP_TOUCH) begin
                    ex_row[w].stamp = r_time;
                end
                if (r_op == OP_DELETE) begin
                    ex_row[w].valid = 1'b0;
                end
            end
            if (sel_f[w] && !any_m && r_op == OP_LEARN) begin
                ex_row[w].valid = 1'b1;
                ex_row[w].addr  = r_mac;
                ex_row[w].port  = r_port;
                ex_row[w].stamp = 32'd0;
            end
        end
    end

    // Bucket row processing for port walks and aging sweeps
    t_row         sw_row;
    logic [CW-1:0] sw_cnt;
    logic [10:0]  sw_sum;
    logic         sw_hit;

    always_comb begin
        sw_row = r_rd_row;
        sw_cnt = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_op == OP_TICK) begin
                sw_hit = r_rd_row[w].valid &&
                         ({1'b0, r_rd_row[w].stamp} + {17'd0, r_expire}) < {1'b0, r_time};
            end else begin
                sw_hit = r_rd_row[w].valid && r_rd_row[w].port == r_port;
            end
            if (sw_hit) begin
                if (r_op == OP_REASSIGN) begin
                    sw_row[w].port = r_new_port;
                end else begin
                    sw_row[w].valid = 1'b0;
                    sw_cnt = sw_cnt + CW'(1);
                end
            end
        end
        sw_sum = {1'b0, r_removed} + 11'(sw_cnt);
    end

    // Memory port control
    logic          mem_we;
    logic [BW-1:0] mem_waddr, mem_raddr;
    t_row          mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wrow;
        mem_wdata = sw_row;
        mem_raddr = r_bucket;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_row[BW-1:0];
                mem_wdata = '0;
            end
            S_EXEC: begin
                mem_we    = 1'b1;
                mem_waddr = r_bucket;
                mem_wdata = ex_row;
            end
            S_SWEEP: begin
                mem_we    = r_pend;
                mem_raddr = r_row[BW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_row <= r_mem[mem_raddr];
    end

    // Tick arithmetic
    logic [31:0] tk_time;
    logic [7:0]  tk_div, tk_limit;

    always_comb begin
        tk_time  = (r_time == 32'hFFFF_FFFF) ? r_time : r_time + 32'd1;
        tk_div   = r_div + 8'd1;
        tk_limit = (r_interval == 8'd0) ? 8'd1 : r_interval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_pend      <= 1'b0;
            r_time      <= 32'd0;
            r_div       <= 8'd0;
            r_expire    <= EXPIRE_RST;
            r_interval  <= INTERVAL_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPIRE:   r_expire <= i_cfg_data;
                    CFG_INTERVAL: r_interval <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            // the push state reloads the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_PUSH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == (BW + 1)'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_operation;
                        r_mac      <= i_mac;
                        r_port     <= i_port;
                        r_new_port <= i_new_port;
                        r_sum      <= f_byte_sum(i_mac);
                        r_hit      <= 1'b0;
                        r_fport    <= 8'd0;
                        r_status   <= ST_DONE;
                        r_removed  <= 10'd0;
                        r_state    <= S_H1;
                    end
                end
                S_H1: begin
                    r_x   <= {4'd0, f_mod11(r_sum)} ^ r_mac[15:8] ^ r_mac[7:0];
                    r_row <= '0;
                    r_pend <= 1'b0;
                    case (r_op)
                        OP_LOOKUP, OP_LEARN, OP_TOUCH, OP_DELETE: r_state <= S_H2;
                        OP_DEL_PORT, OP_REASSIGN: r_state <= S_SWEEP;
                        OP_TICK: begin
                            r_time <= tk_time;
                            if (tk_div >= tk_limit) begin
                                r_div   <= 8'd0;
                                r_state <= S_SWEEP;
                            end else begin
                                r_div   <= tk_div;
                                r_state <= S_PUSH;
                            end
                        end
                        default: r_state <= S_PUSH;
                    endcase
                end
                S_H2: begin
                    r_bucket <= br[BW-1:0];
                    r_state  <= S_RD;
                end
                S_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_hit   <= any_m;
                    r_fport <= m_port;
                    if (!any_m) begin
                        if (r_op == OP_LEARN) begin
                            r_status <= any_f ? ST_DONE : ST_FULL;
                        end else begin
                            r_status <= ST_MISS;
                        end
                    end else if (r_op == OP_LEARN) begin
                        r_status <= ST_PRESENT;
                    end
                    r_state <= S_PUSH;
                end
                S_SWEEP: begin
                    // issue the read of one row while the previous row is written back
                    r_wrow <= r_row[BW-1:0];
                    r_pend <= (r_row != (BW + 1)'(BUCKETS));
                    if (r_row != (BW + 1)'(BUCKETS)) begin
                        r_row <= r_row + 1'b1;
                    end
                    if (r_pend) begin
                        r_removed <= (sw_sum > 11'(REMOVED_MAX)) ? REMOVED_MAX : sw_sum[9:0];
                    end
                    if (r_row == (BW + 1)'(BUCKETS) && !r_pend) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_hit     <= r_hit;
                        r_o_fport   <= r_fport;
                        r_o_status  <= r_status;
                        r_o_removed <= r_removed;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_found_port    = r_o_fport;
    assign o_status        = r_o_status;
    assign o_removed_count = r_o_removed;

    `MLT_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall)
    `MLT_ASSERT(a_clear_stalls, (r_state != S_CLEAR) || o_in_stall)
    `MLT_ASSERT(a_removed_no_hit, !o_out_valid || o_removed_count == 10'd0 || (!o_hit && o_status == ST_DONE))
    `MLT_ASSERT(a_full_no_hit, !o_out_valid || o_status != ST_FULL || !o_hit)

endmodule
